// ===== src/ffha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = 4;
    localparam int CFG_W      = 12;
    localparam int OFF_W      = 15;
    localparam int REQ_W      = 16;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_code_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OOM      = 2'd1,
        STAT_BAD_FREE = 2'd2
    } status_t;

    typedef struct packed {
        cmd_code_t         command;
        logic [REQ_W-1:0]  request_bytes;
        logic [OFF_W-1:0]  release_offset;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [OFF_W-1:0]  granted_offset;
    } rsp_t;

    // Finished result offered by the sequencer to the output register.
    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } done_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_EVAL,
        ST_A_SPLIT,
        ST_A_MARK,
        ST_A_FIX,
        ST_F_CHECK,
        ST_M_READ,
        ST_M_CUR,
        ST_M_NEXT,
        ST_M_CLR,
        ST_M_SUCC,
        ST_M_FIX,
        ST_M_END,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== src/ffha_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/ffha_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer around the chunk header memory: clearing pass, first-fit scan,
// split, free checks and the two merge passes.
// ----------------------------------------------------------------------------
module ffha_ctrl #(
    parameter int MAX_UNITS = 2048
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                restart,
    input  wire logic [$clog2(MAX_UNITS+1)-1:0]      heap_units,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire ffha_pkg::cmd_t                      in_data,
    output ffha_pkg::done_t                          done,
    input  wire logic                                done_ack
);
    import ffha_pkg::*;

    localparam int UW  = $clog2(MAX_UNITS + 1);
    localparam int AW  = $clog2(MAX_UNITS);
    localparam int WW  = (UW > 13) ? UW + 1 : 14;
    localparam int WDW = 2 + UW + AW;

    state_t           state_reg, state_next;
    logic [UW-1:0]    clr_idx_reg, clr_idx_next;
    logic [AW-1:0]    c_reg, c_next;
    logic [AW-1:0]    cc_reg, cc_next;
    logic [AW-1:0]    n_reg, n_next;
    logic [AW-1:0]    prev_c_reg, prev_c_next;
    logic [UW-1:0]    len_reg, len_next;
    logic [WW-1:0]    need_reg, need_next;
    logic [WDW-1:0]   word_reg, word_next;
    logic             split_reg, split_next;
    logic             phase_reg, phase_next;
    rsp_t             rsp_reg, rsp_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [WDW-1:0]   wdata, rdata;

    logic             rd_start, rd_used;
    logic [UW-1:0]    rd_len;
    logic [AW-1:0]    rd_prev;
    logic [WW-1:0]    heap_w, c_w, cc_w, len_w, rd_len_w, need_w, off_c_w, scan_next_w;
    logic [WW-1:0]    after_w, sum_w;
    logic [16:0]      rounded;
    logic             accept, free_ok, fit;
    logic [31:0]      grant_w;

    assign rd_start = rdata[WDW-1];
    assign rd_used  = rdata[WDW-2];
    assign rd_len   = rdata[AW+UW-1:AW];
    assign rd_prev  = rdata[AW-1:0];

    assign accept   = in_valid && in_ready;
    assign heap_w   = WW'(heap_units);
    assign c_w      = WW'(c_reg);
    assign cc_w     = WW'(cc_reg);
    assign len_w    = WW'(len_reg);
    assign rd_len_w = WW'(rd_len);

    // Units wanted: payload rounded up to whole units plus the header unit.
    assign rounded  = {1'b0, in_data.request_bytes} + 17'(UNIT_BYTES - 1);
    assign need_w   = WW'(rounded >> UNIT_SHIFT) + WW'(1);

    assign off_c_w  = WW'(in_data.release_offset >> UNIT_SHIFT) - WW'(1);
    assign free_ok  = (in_data.release_offset[UNIT_SHIFT-1:0] == '0)
                   && (in_data.release_offset >= OFF_W'(UNIT_BYTES))
                   && (off_c_w < heap_w);

    assign fit         = !rd_used && (rd_len_w >= need_reg);
    assign scan_next_w = c_w + rd_len_w;
    assign after_w     = c_w + len_w;
    assign sum_w       = cc_w + len_w;
    assign grant_w     = (32'(c_reg) + 32'd1) << UNIT_SHIFT;

    ffha_ram #(
        .WIDTH (WDW),
        .DEPTH (MAX_UNITS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg      <= c_next;
        cc_reg     <= cc_next;
        n_reg      <= n_next;
        prev_c_reg <= prev_c_next;
        len_reg    <= len_next;
        need_reg   <= need_next;
        word_reg   <= word_next;
        split_reg  <= split_next;
        phase_reg  <= phase_next;
        rsp_reg    <= rsp_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == UW'(MAX_UNITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.command == CMD_ALLOC)
                    begin
                        state_next = ST_A_EVAL;
                    end
                    else if (free_ok)
                    begin
                        state_next = ST_F_CHECK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_A_EVAL:
            begin
                if (rd_len == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (fit)
                begin
                    state_next = (rd_len_w - need_reg > WW'(2)) ? ST_A_SPLIT : ST_A_MARK;
                end
                else if (scan_next_w >= heap_w)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_A_SPLIT: state_next = ST_A_MARK;
            ST_A_MARK:
            begin
                state_next = (split_reg && after_w < heap_w) ? ST_A_FIX : ST_DONE;
            end
            ST_A_FIX:   state_next = ST_DONE;
            ST_F_CHECK:
            begin
                state_next = (rd_start && rd_used) ? ST_M_READ : ST_DONE;
            end
            ST_M_READ:
            begin
                state_next = (cc_w < heap_w) ? ST_M_CUR : ST_M_END;
            end
            ST_M_CUR:
            begin
                if (rd_used || (cc_w + rd_len_w >= heap_w))
                begin
                    state_next = ST_M_END;
                end
                else
                begin
                    state_next = ST_M_NEXT;
                end
            end
            ST_M_NEXT:  state_next = rd_used ? ST_M_END : ST_M_CLR;
            ST_M_CLR:   state_next = ST_M_SUCC;
            ST_M_SUCC:  state_next = (sum_w < heap_w) ? ST_M_FIX : ST_M_END;
            ST_M_FIX:   state_next = ST_M_END;
            ST_M_END:
            begin
                state_next = (!phase_reg && c_reg != '0) ? ST_M_READ : ST_DONE;
            end
            ST_DONE:
            begin
                if (done_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
        if (restart)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Memory control and datapath registers.
    always_comb
    begin
        we           = 1'b0;
        waddr        = c_reg;
        wdata        = '0;
        raddr        = c_reg;
        clr_idx_next = clr_idx_reg;
        c_next       = c_reg;
        cc_next      = cc_reg;
        n_next       = n_reg;
        prev_c_next  = prev_c_reg;
        len_next     = len_reg;
        need_next    = need_reg;
        word_next    = word_reg;
        split_next   = split_reg;
        phase_next   = phase_reg;
        rsp_next     = rsp_reg;
        in_ready     = (state_reg == ST_IDLE);
        done.valid   = (state_reg == ST_DONE);
        done.rsp     = rsp_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_idx_reg[AW-1:0];
                wdata        = (clr_idx_reg == '0) ? {1'b1, 1'b0, heap_units, AW'(0)} : '0;
                clr_idx_next = clr_idx_reg + UW'(1);
            end
            ST_IDLE:
            begin
                c_next     = (in_data.command == CMD_ALLOC) ? '0 : off_c_w[AW-1:0];
                raddr      = c_next;
                need_next  = need_w;
                phase_next = 1'b0;
                split_next = 1'b0;
                rsp_next   = '{status: (in_data.command == CMD_ALLOC) ? STAT_OOM
                                       : (free_ok ? STAT_OK : STAT_BAD_FREE),
                               granted_offset: '0};
            end
            ST_A_EVAL:
            begin
                len_next    = rd_len;
                prev_c_next = rd_prev;
                if (rd_len != '0 && fit)
                begin
                    split_next = (rd_len_w - need_reg > WW'(2));
                end
                else if (rd_len != '0 && scan_next_w < heap_w)
                begin
                    c_next = scan_next_w[AW-1:0];
                    raddr  = c_next;
                end
            end
            ST_A_SPLIT:
            begin
                n_next = c_reg + need_reg[AW-1:0];
                we     = 1'b1;
                waddr  = n_next;
                wdata  = {1'b1, 1'b0, len_reg - need_reg[UW-1:0], c_reg};
            end
            ST_A_MARK:
            begin
                we       = 1'b1;
                waddr    = c_reg;
                wdata    = {1'b1, 1'b1, split_reg ? need_reg[UW-1:0] : len_reg, prev_c_reg};
                raddr    = after_w[AW-1:0];
                rsp_next = '{status: STAT_OK, granted_offset: grant_w[OFF_W-1:0]};
            end
            ST_A_FIX:
            begin
                we    = 1'b1;
                waddr = after_w[AW-1:0];
                wdata = {rdata[WDW-1:AW], n_reg};
            end
            ST_F_CHECK:
            begin
                prev_c_next = rd_prev;
                cc_next     = c_reg;
                if (rd_start && rd_used)
                begin
                    we    = 1'b1;
                    waddr = c_reg;
                    wdata = {1'b1, 1'b0, rd_len, rd_prev};
                end
                else
                begin
                    rsp_next = '{status: STAT_BAD_FREE, granted_offset: '0};
                end
            end
            ST_M_READ:
            begin
                raddr = cc_reg;
            end
            ST_M_CUR:
            begin
                word_next = rdata;
                len_next  = rd_len;
                n_next    = cc_reg + rd_len[AW-1:0];
                raddr     = n_next;
            end
            ST_M_NEXT:
            begin
                if (!rd_used)
                begin
                    // The merged length never exceeds the heap, so it fits.
                    len_next = len_reg + rd_len;
                    we       = 1'b1;
                    waddr    = cc_reg;
                    wdata    = {word_reg[WDW-1], 1'b0, len_next, word_reg[AW-1:0]};
                    word_next = rdata;
                end
            end
            ST_M_CLR:
            begin
                we    = 1'b1;
                waddr = n_reg;
                wdata = {1'b0, word_reg[WDW-2], UW'(0), word_reg[AW-1:0]};
            end
            ST_M_SUCC:
            begin
                raddr = sum_w[AW-1:0];
            end
            ST_M_FIX:
            begin
                we    = 1'b1;
                waddr = sum_w[AW-1:0];
                wdata = {rdata[WDW-1:AW], cc_reg};
            end
            ST_M_END:
            begin
                if (!phase_reg && c_reg != '0)
                begin
                    phase_next = 1'b1;
                    cc_next    = prev_c_reg;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (restart)
        begin
            clr_idx_next = '0;
        end
    end

endmodule
`default_nettype wire

// ===== src/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a heap of 16-byte units with chunk coalescing.
//
//   Channel | Signals                          | Transaction
//   --------+----------------------------------+------------------------------
//   in      | in_valid, in_ready, in_data      | one allocate or free command
//   out     | out_valid, out_ready, out_data   | status and granted offset
//   cfg     | cfg_wr_en, cfg_wr_data           | heap size write, no wait
//
// Allocate scans chunks from the heap start, splits the chosen one when over
// two units would be left, marks it used and relinks the next chunk. Free
// checks the offset and header, then merges forward from the freed chunk and
// from its predecessor. Chunk headers live in one RAM with registered reads.
// Reset and every heap size write start a clearing pass with in_ready low.
// A stalled result holds the sequencer in its final step until it is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int MAX_UNITS = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire ffha_pkg::cmd_t               in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output ffha_pkg::rsp_t                    out_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ffha_pkg::CFG_W-1:0]   cfg_wr_data
);
    import ffha_pkg::*;

    localparam int UW = $clog2(MAX_UNITS + 1);
    localparam logic [UW-1:0] RESET_UNITS = UW'((MAX_UNITS < 2048) ? MAX_UNITS : 2048);

    logic [UW-1:0] heap_units_reg, heap_units_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_data_reg, out_data_next;
    done_t         done;
    logic          done_ack;
    logic [31:0]   cfg_w;

    assign cfg_w    = 32'(cfg_wr_data);
    assign done_ack = !out_valid_reg || out_ready;

    always_comb
    begin
        heap_units_next = heap_units_reg;
        if (cfg_wr_en)
        begin
            if (cfg_w < 32'd2)
            begin
                heap_units_next = UW'(2);
            end
            else if (cfg_w > 32'(MAX_UNITS))
            begin
                heap_units_next = UW'(MAX_UNITS);
            end
            else
            begin
                heap_units_next = UW'(cfg_w);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (done.valid && done_ack)
        begin
            out_valid_next = 1'b1;
            out_data_next  = done.rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_units_reg <= RESET_UNITS;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            heap_units_reg <= heap_units_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ffha_ctrl #(
        .MAX_UNITS (MAX_UNITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr_en),
        .heap_units (heap_units_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .done       (done),
        .done_ack   (done_ack)
    );

endmodule
`default_nettype wire

// ===== src/ffha_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire ffha_pkg::rsp_t  out_data,
    input  wire logic            cfg_wr_en
);
    import ffha_pkg::*;

    // A waiting result must not change under back-pressure.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_OOM
                       || out_data.status == STAT_BAD_FREE))
        else $error("unknown status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |-> out_data.granted_offset == '0)
        else $error("failed transaction carries an offset");

    // Commands are handled one at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while busy");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !in_ready)
        else $error("command taken during heap clear");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en)
);
`default_nettype wire

// ===== tb/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator. A directed table of
// allocate and free commands is followed by random allocate/free traffic over
// several heap sizes. A behavioral heap model predicts every response.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int HEAP_MAX      = 2048;
    localparam int IDLE_LIMIT    = 20000;
    localparam int HEAP_RESET    = 2048;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    cmd_t       in_data;
    logic       out_valid;
    logic       out_ready;
    rsp_t       out_data;
    logic       cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    first_fit_heap_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Heap shadow state.
    int unsigned heap_size;
    bit          chunk_start [HEAP_MAX];
    bit          chunk_used  [HEAP_MAX];
    int unsigned chunk_len   [HEAP_MAX];
    int unsigned chunk_prev  [HEAP_MAX];

    rsp_t        pending_rsp [$];
    int unsigned live_offsets [$];
    int          error_count;
    int          idle_cycles;
    bit          no_idle;

    typedef struct {
        cmd_code_t   command;
        int unsigned bytes;
        int unsigned offset;
        bit          has_expect;
        status_t     exp_status;
        int unsigned exp_offset;
    } stim_row_t;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic heap_clear(input int unsigned units);
        if (units < 2) units = 2;
        if (units > HEAP_MAX) units = HEAP_MAX;
        heap_size = units;
        for (int i = 0; i < HEAP_MAX; i++)
        begin
            chunk_start[i] = 1'b0;
            chunk_used[i]  = 1'b0;
            chunk_len[i]   = 0;
            chunk_prev[i]  = 0;
        end
        chunk_start[0] = 1'b1;
        chunk_len[0]   = units;
        live_offsets.delete();
    endtask

    function automatic void coalesce_forward(input int unsigned c);
        int unsigned n;
        if (c >= heap_size || chunk_used[c]) return;
        n = c + chunk_len[c];
        if (n >= heap_size || chunk_used[n]) return;
        chunk_len[c] += chunk_len[n];
        chunk_start[n] = 1'b0;
        chunk_len[n]   = 0;
        n = c + chunk_len[c];
        if (n < heap_size) chunk_prev[n] = c;
    endfunction

    function automatic rsp_t heap_apply(input cmd_t cmd);
        rsp_t        r;
        int unsigned need, c, len, n, off;
        bit          found;
        r.status = STAT_OK;
        r.granted_offset = '0;
        if (cmd.command == CMD_ALLOC)
        begin
            need = (int'(cmd.request_bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
            c = 0;
            found = 1'b0;
            while (c < heap_size)
            begin
                len = chunk_len[c];
                if (len == 0) break;
                if (!chunk_used[c] && len >= need)
                begin
                    found = 1'b1;
                    break;
                end
                c += len;
            end
            if (!found)
            begin
                r.status = STAT_OOM;
                return r;
            end
            if (chunk_len[c] - need > 2)
            begin
                len = chunk_len[c];
                n = c + need;
                chunk_start[n] = 1'b1;
                chunk_used[n]  = 1'b0;
                chunk_len[n]   = len - need;
                chunk_prev[n]  = c;
                if (c + len < heap_size) chunk_prev[c + len] = n;
                chunk_len[c] = need;
            end
            chunk_used[c] = 1'b1;
            r.granted_offset = OFF_W'((c + 1) * UNIT_BYTES);
            live_offsets.push_back((c + 1) * UNIT_BYTES);
        end
        else
        begin
            off = cmd.release_offset;
            if (off % UNIT_BYTES != 0 || off < UNIT_BYTES)
            begin
                r.status = STAT_BAD_FREE;
                return r;
            end
            c = off / UNIT_BYTES - 1;
            if (c >= heap_size || !chunk_start[c] || !chunk_used[c])
            begin
                r.status = STAT_BAD_FREE;
                return r;
            end
            chunk_used[c] = 1'b0;
            coalesce_forward(c);
            if (c != 0) coalesce_forward(chunk_prev[c]);
            foreach (live_offsets[i])
                if (live_offsets[i] == off)
                begin
                    live_offsets.delete(i);
                    break;
                end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Response checker and idle watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("unexpected response", 1, 0);
                else
                begin
                    if (out_data.status != pending_rsp[0].status)
                        report_mismatch("status", out_data.status, pending_rsp[0].status);
                    if (out_data.granted_offset != pending_rsp[0].granted_offset)
                        report_mismatch("granted_offset", out_data.granted_offset,
                                        pending_rsp[0].granted_offset);
                    void'(pending_rsp.pop_front());
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver stalls in random bursts.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Valid stays high after the last transaction until the next command
    // replaces the payload, an idle gap begins or the caller drops it.
    task automatic send_command(input cmd_t cmd);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= cmd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_rsp.push_back(heap_apply(cmd));
        @(negedge clk);
    endtask

    task automatic write_heap_size(input logic [CFG_W-1:0] units);
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= units;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        heap_clear(units);
    endtask

    function automatic cmd_t make_alloc(input int unsigned bytes);
        cmd_t c;
        c.command = CMD_ALLOC;
        c.request_bytes = REQ_W'(bytes);
        c.release_offset = OFF_W'($urandom);
        return c;
    endfunction

    function automatic cmd_t make_free(input int unsigned off);
        cmd_t c;
        c.command = CMD_FREE;
        c.request_bytes = REQ_W'($urandom);
        c.release_offset = OFF_W'(off);
        return c;
    endfunction

    task automatic random_phase(input int count, input int max_bytes);
        cmd_t c;
        int   pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                c = make_alloc($urandom_range(0, max_bytes));
            else if (pick < 52)
                c = make_alloc($urandom);
            else if (pick < 88 && live_offsets.size() != 0)
                c = make_free(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            else if (pick < 94)
                c = make_free($urandom_range(0, 2 * heap_size) * UNIT_BYTES);
            else
                c = make_free($urandom);
            send_command(c);
        end
    endtask

    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t row;
        cmd_t      c;
        rsp_t      want;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        error_count = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        heap_clear(HEAP_RESET);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table on the reset heap: first allocation lands right
        // after the header, frees of bad offsets are refused.
        table_rows = '{
            '{CMD_ALLOC, 0,     0,     1, STAT_OK,       16},
            '{CMD_ALLOC, 1,     0,     1, STAT_OK,       32},
            '{CMD_ALLOC, 16,    0,     0, STAT_OK,       0},
            '{CMD_ALLOC, 65535, 0,     1, STAT_OOM,      0},
            '{CMD_FREE,  0,     0,     1, STAT_BAD_FREE, 0},
            '{CMD_FREE,  0,     8,     1, STAT_BAD_FREE, 0},
            '{CMD_FREE,  0,     17,    1, STAT_BAD_FREE, 0},
            '{CMD_FREE,  0,     48,    1, STAT_BAD_FREE, 0},
            '{CMD_FREE,  0,     32767, 1, STAT_BAD_FREE, 0},
            '{CMD_FREE,  0,     32,    1, STAT_OK,       0},
            '{CMD_FREE,  0,     32,    1, STAT_BAD_FREE, 0},
            '{CMD_FREE,  0,     16,    1, STAT_OK,       0},
            '{CMD_ALLOC, 32752, 0,     0, STAT_OK,       0},
            '{CMD_FREE,  0,     16,    0, STAT_OK,       0},
            '{CMD_ALLOC, 65535, 0,     1, STAT_OOM,      0}
        };
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            if (row.command == CMD_ALLOC) c = make_alloc(row.bytes);
            else c = make_free(row.offset);
            send_command(c);
            want = pending_rsp[$];
            if (row.has_expect && (want.status != row.exp_status
                || want.granted_offset != OFF_W'(row.exp_offset)))
                report_mismatch("table row", i, row.exp_status);
        end

        // Smallest heap: only a header plus one unit fits.
        write_heap_size(12'd0);
        send_command(make_alloc(17));
        send_command(make_alloc(16));
        send_command(make_free(16));
        send_command(make_free(15 * HEAP_MAX));

        write_heap_size(12'd40);
        random_phase(150, 200);
        write_heap_size(12'd3);
        random_phase(50, 40);
        write_heap_size(12'd4095);
        random_phase(150, 1500);
        write_heap_size(12'd2048);
        random_phase(100, 4000);
        no_idle = 1'b1;
        write_heap_size(12'd100);
        random_phase(150, 300);

        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
src/ffha_pkg.sv
src/ffha_ram.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator.sv
src/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
